[hw/rtl/vbtpl_pkg.sv]
// Shared types and constants for the voice bank two-pole lowpass.
`timescale 1ns / 1ps
package vbtpl_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INTEG_BITS  = SAMPLE_BITS + 2;
  localparam int COEF_BITS   = 17;
  localparam int NOTE_BITS   = 7;
  localparam int OFFSET_BITS = 6;
  localparam int VOICE_BITS  = 4;
  localparam int MULT_BITS   = 5;

  localparam int NUM_VOICES_DEF     = 16;
  localparam int NUM_NOTES_DEF      = 120;
  localparam int SAMPLE_RATE_HZ_DEF = 48000;

  localparam logic [NOTE_BITS-1:0] BASE_NOTE_RESET = 7'd48;
  localparam logic [MULT_BITS-1:0] DEFAULT_MULT_RESET = 5'd1;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_NOTE   = 2'd1,
    FUNC_MULT   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_NOTE,
    OP_OFFSET
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic [VOICE_BITS-1:0]        voice;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [NOTE_BITS-1:0]         note;
    logic [OFFSET_BITS-1:0]       offset;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STAGE1,
    BK_STAGE2
  } back_state_t;

endpackage

[hw/rtl/vbtpl_if.sv]
// Valid/ready channel interfaces for input items and filtered levels.
`timescale 1ns / 1ps
interface vbtpl_in_if;
  import vbtpl_pkg::*;
  logic                          valid;
  logic                          ready;
  func_t                         func;
  logic [VOICE_BITS-1:0]         voice;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [NOTE_BITS-1:0]          note;
  logic [MULT_BITS-1:0]          harmonic_multiple;

  modport source (output valid, func, voice, sample, note, harmonic_multiple, input ready);
  modport sink   (input valid, func, voice, sample, note, harmonic_multiple, output ready);
endinterface

interface vbtpl_out_if;
  import vbtpl_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [VOICE_BITS-1:0]         out_voice;
  logic signed [SAMPLE_BITS-1:0] level;

  modport source (output valid, out_voice, level, input ready);
  modport sink   (input valid, out_voice, level, output ready);
endinterface

[hw/rtl/voice_bank_two_pole_lowpass.sv]
// Top level of the per-voice two-pole zero-delay-feedback lowpass bank.
//
// Channels: in_ch takes items (func, voice, sample, note, harmonic_multiple);
// func 0 filters one sample and yields one result on out_ch (out_voice, level),
// func 1 sets a voice's base note, func 2 sets its harmonic multiple. Items
// with func 3 or a voice beyond the bank are taken and dropped.
// cfg_wr_en/cfg_wr_data write the default harmonic multiple.
// The front end classifies each transfer into a two-entry command queue; the
// back end runs it. A note or multiple item is applied when it is popped. A
// sample item runs in order: read the cutoff coefficient, run the first
// integrator stage, run the second stage into the output register. The two
// integrator stages share one sequence, so the back end takes no new item
// until the previous sample item has left the second stage.
// Reset (synchronous, rst_n low for one cycle) sets every voice to note 48,
// offset zero and cleared integrators, and the default multiple to 1.
// When the receiver stalls, the result holds in the output register, the next
// sample item waits in the second stage, the queue fills and in_ch.ready drops.
`timescale 1ns / 1ps
module voice_bank_two_pole_lowpass
  import vbtpl_pkg::*;
#(
  parameter int NUM_VOICES     = NUM_VOICES_DEF,
  parameter int NUM_NOTES      = NUM_NOTES_DEF,
  parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  vbtpl_in_if.sink             in_ch,
  vbtpl_out_if.source          out_ch,
  input  logic                 cfg_wr_en,
  input  logic [MULT_BITS-1:0] cfg_wr_data
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic fifo_full;
  logic fifo_empty;

  vbtpl_front #(
    .NUM_VOICES (NUM_VOICES),
    .NUM_NOTES  (NUM_NOTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  vbtpl_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  vbtpl_back #(
    .NUM_VOICES     (NUM_VOICES),
    .NUM_NOTES      (NUM_NOTES),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[hw/rtl/vbtpl_front.sv]
// Front end: accepts items, drops the ones that do nothing, maps multiples to offsets.
`timescale 1ns / 1ps
module vbtpl_front
  import vbtpl_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF,
  parameter int NUM_NOTES  = NUM_NOTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  vbtpl_in_if.sink             in_ch,
  input  logic                 cfg_wr_en,
  input  logic [MULT_BITS-1:0] cfg_wr_data,
  input  logic                 fifo_full,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [MULT_BITS-1:0] default_mult_r;
  logic                 accept;
  logic                 voice_ok;
  logic                 note_ok;

  function automatic logic [OFFSET_BITS-1:0] offset_table(logic [3:0] idx);
    logic [OFFSET_BITS-1:0] off;
    case (idx)
      4'd0:    off = 6'd0;
      4'd1:    off = 6'd12;
      4'd2:    off = 6'd19;
      4'd3:    off = 6'd24;
      4'd4:    off = 6'd28;
      4'd5:    off = 6'd31;
      4'd6:    off = 6'd34;
      4'd7:    off = 6'd36;
      4'd8:    off = 6'd38;
      4'd9:    off = 6'd40;
      4'd10:   off = 6'd42;
      4'd11:   off = 6'd43;
      4'd12:   off = 6'd44;
      4'd13:   off = 6'd46;
      4'd14:   off = 6'd47;
      default: off = 6'd48;
    endcase
    return off;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] mult_offset(logic [MULT_BITS-1:0] mult,
                                                          logic [MULT_BITS-1:0] dflt);
    logic [MULT_BITS-1:0] m;
    if (mult inside {[5'd1:5'd16]}) begin
      m = mult - 5'd1;
    end else if (dflt inside {[5'd1:5'd16]}) begin
      m = dflt - 5'd1;
    end else begin
      m = '0;
    end
    return offset_table(m[3:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_mult_r <= DEFAULT_MULT_RESET;
    end else if (cfg_wr_en) begin
      default_mult_r <= cfg_wr_data;
    end
  end

  assign in_ch.ready = !fifo_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign voice_ok    = 9'(in_ch.voice) < 9'(NUM_VOICES);
  assign note_ok     = 8'(in_ch.note) < 8'(NUM_NOTES);

  always_comb begin
    push_cmd.voice  = in_ch.voice;
    push_cmd.sample = in_ch.sample;
    push_cmd.note   = in_ch.note;
    push_cmd.offset = mult_offset(in_ch.harmonic_multiple, default_mult_r);
    push_cmd.op     = OP_SAMPLE;
    push            = 1'b0;
    case (in_ch.func)
      FUNC_SAMPLE: begin
        push_cmd.op = OP_SAMPLE;
        push        = accept && voice_ok;
      end
      FUNC_NOTE: begin
        push_cmd.op = OP_NOTE;
        push        = accept && voice_ok && note_ok;
      end
      FUNC_MULT: begin
        push_cmd.op = OP_OFFSET;
        push        = accept && voice_ok;
      end
      default: begin
        // drop unused codes
        push = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/vbtpl_cmd_fifo.sv]
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
module vbtpl_cmd_fifo
  import vbtpl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/vbtpl_back.sv]
// Back end: per-voice note stores and the two trapezoidal integrator stages.
`timescale 1ns / 1ps
module vbtpl_back
  import vbtpl_pkg::*;
#(
  parameter int NUM_VOICES     = NUM_VOICES_DEF,
  parameter int NUM_NOTES      = NUM_NOTES_DEF,
  parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fifo_empty,
  input  cmd_t        head,
  output logic        pop,
  vbtpl_out_if.source out_ch
);

  typedef logic [COEF_BITS-1:0] coef_rom_t [128];

  typedef struct packed {
    logic signed [21:0]           y;
    logic signed [INTEG_BITS-1:0] s;
  } stage_res_t;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  function automatic longint unsigned semitone_q30(int i);
    longint unsigned r;
    case (i)
      0:       r = 64'd1073741824;
      1:       r = 64'd1137589835;
      2:       r = 64'd1205234447;
      3:       r = 64'd1276901417;
      4:       r = 64'd1352829926;
      5:       r = 64'd1433273380;
      6:       r = 64'd1518500250;
      7:       r = 64'd1608794974;
      8:       r = 64'd1704458901;
      9:       r = 64'd1805811301;
      10:      r = 64'd1913190429;
      default: r = 64'd2026954652;
    endcase
    return r;
  endfunction

  // g = s / (s + c) in Q15 with tan pre-warp, sin and cos by Taylor series in Q30
  function automatic logic [COEF_BITS-1:0] coef_for_note(int m, int Rate);
    longint unsigned num, ratio, x, x2, ts, tc, Div;
    longint          s, c, Den;
    int              n, q;
    n     = m + 3;
    q     = n / 12;
    num   = (64'd440 * semitone_q30(n % 12)) << q;
    Div   = 64'd8 * 64'(Rate);
    ratio = num / Div;
    if (ratio >= (64'd1 << 31)) begin
      return 17'd32768;
    end
    x  = (ratio * PI_Q30) >> 32;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    s  = longint'(x);
    c  = longint'(tc);
    for (int k = 1; k <= 12; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    if (s < 0) s = 0;
    if (c < 0) c = 0;
    Den = s + c;
    if (Den == 0) begin
      return 17'd32768;
    end
    return COEF_BITS'((s * 32768 + Den / 2) / Den);
  endfunction

  function automatic coef_rom_t build_coef_rom(int NumNotes, int Rate);
    coef_rom_t rom;
    for (int i = 0; i < 128; i++) begin
      rom[i] = (i < NumNotes) ? coef_for_note(i, Rate) : '0;
    end
    return rom;
  endfunction

  localparam int NV = (NUM_VOICES < 16) ? NUM_VOICES : 16;
  localparam int VW = (NV > 1) ? $clog2(NV) : 1;
  localparam logic [NOTE_BITS-1:0] CUT_MAX = NOTE_BITS'(NUM_NOTES - 1);
  localparam logic [NOTE_BITS-1:0] CUT_RESET =
    (int'(BASE_NOTE_RESET) > NUM_NOTES - 1) ? CUT_MAX : BASE_NOTE_RESET;
  localparam coef_rom_t COEF_ROM = build_coef_rom(NUM_NOTES, SAMPLE_RATE_HZ);

  function automatic logic [NOTE_BITS-1:0] clamp_cut(logic [NOTE_BITS-1:0] base,
                                                     logic [OFFSET_BITS-1:0] off);
    logic [NOTE_BITS:0] sum;
    sum = {1'b0, base} + {2'b00, off};
    return (sum > {1'b0, CUT_MAX}) ? CUT_MAX : sum[NOTE_BITS-1:0];
  endfunction

  function automatic logic signed [INTEG_BITS-1:0] sat_integ(logic signed [22:0] v);
    if (v > 23'sd131071) return 18'sd131071;
    if (v < -23'sd131072) return -18'sd131072;
    return v[INTEG_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_level(logic signed [21:0] v);
    if (v > 22'sd32767) return 16'sd32767;
    if (v < -22'sd32768) return -16'sd32768;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // v = (x - s) * g / 32768 toward zero, y = v + s, s' = sat(y + v)
  function automatic stage_res_t run_stage(logic signed [19:0] x,
                                           logic signed [INTEG_BITS-1:0] s,
                                           logic [COEF_BITS-1:0] g);
    logic signed [20:0] diff;
    logic signed [38:0] prod;
    logic signed [38:0] adj;
    logic signed [20:0] v;
    logic signed [22:0] ns;
    stage_res_t         res;
    diff  = {x[19], x} - {{3{s[INTEG_BITS-1]}}, s};
    prod  = 39'(diff) * 39'($signed({1'b0, g}));
    adj   = prod[38] ? prod + 39'sd32767 : prod;
    v     = 21'(adj >>> 15);
    res.y = {v[20], v} + {{4{s[INTEG_BITS-1]}}, s};
    ns    = {res.y[21], res.y} + {{2{v[20]}}, v};
    res.s = sat_integ(ns);
    return res;
  endfunction

  logic [NOTE_BITS-1:0]          base_r   [NV];
  logic [OFFSET_BITS-1:0]        offset_r [NV];
  logic [NOTE_BITS-1:0]          cutoff_r [NV];
  logic signed [INTEG_BITS-1:0]  s1_r     [NV];
  logic signed [INTEG_BITS-1:0]  s2_r     [NV];

  back_state_t                   state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [VOICE_BITS-1:0]         voice_r;
  logic [COEF_BITS-1:0]          g_r;
  logic signed [19:0]            y0_r;
  logic                          out_valid_r;
  logic [VOICE_BITS-1:0]         out_voice_r;
  logic signed [SAMPLE_BITS-1:0] level_r;

  logic [VW-1:0] head_idx;
  logic [VW-1:0] cur_idx;
  logic          stage1_en;
  logic          stage2_en;
  stage_res_t    res1;
  stage_res_t    res2;

  assign head_idx = head.voice[VW-1:0];
  assign cur_idx  = voice_r[VW-1:0];
  assign res1     = run_stage({{4{x_r[SAMPLE_BITS-1]}}, x_r}, s1_r[cur_idx], g_r);
  assign res2     = run_stage(y0_r, s2_r[cur_idx], g_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!fifo_empty && head.op == OP_SAMPLE) begin
          state_nxt = BK_STAGE1;
        end
      end
      BK_STAGE1: state_nxt = BK_STAGE2;
      BK_STAGE2: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    stage1_en = 1'b0;
    stage2_en = 1'b0;
    case (state_r)
      BK_IDLE:   pop       = !fifo_empty;
      BK_STAGE1: stage1_en = 1'b1;
      BK_STAGE2: stage2_en = !out_valid_r || out_ch.ready;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        base_r[i]   <= BASE_NOTE_RESET;
        offset_r[i] <= '0;
        cutoff_r[i] <= CUT_RESET;
        s1_r[i]     <= '0;
        s2_r[i]     <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        case (head.op)
          OP_NOTE: begin
            base_r[head_idx]   <= head.note;
            cutoff_r[head_idx] <= clamp_cut(head.note, offset_r[head_idx]);
          end
          OP_OFFSET: begin
            offset_r[head_idx] <= head.offset;
            cutoff_r[head_idx] <= clamp_cut(base_r[head_idx], head.offset);
          end
          default: begin
            // sample: operands latched below
          end
        endcase
      end
      if (stage1_en) begin
        s1_r[cur_idx] <= res1.s;
      end
      if (stage2_en) begin
        s2_r[cur_idx] <= res2.s;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r     <= head.sample;
      voice_r <= head.voice;
      g_r     <= COEF_ROM[cutoff_r[head_idx]];
    end
    if (stage1_en) begin
      // first stage output lies between the input and the state
      y0_r <= res1.y[19:0];
    end
    if (stage2_en) begin
      out_voice_r <= voice_r;
      level_r     <= sat_level(res2.y);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_voice = out_voice_r;
  assign out_ch.level     = level_r;

endmodule

[hw/rtl/vbtpl_checker.sv]
// Port-level checker for the lowpass bank, bound to the top level.
`timescale 1ns / 1ps
module vbtpl_checker
  import vbtpl_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    in_func,
  input logic [VOICE_BITS-1:0]         in_voice,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [VOICE_BITS-1:0]         out_voice,
  input logic signed [SAMPLE_BITS-1:0] out_level
);

  logic [2:0] pending_r;
  logic [2:0] pending_nxt;
  logic       sample_in;
  logic       result_out;

  assign sample_in  = in_valid && in_ready && (in_func == FUNC_SAMPLE) &&
                      (9'(in_voice) < 9'(NUM_VOICES));
  assign result_out = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (sample_in && !result_out) begin
      pending_nxt = pending_r + 3'd1;
    end else if (result_out && !sample_in) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_voice))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without a pending sample item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("more sample items in flight than storage allows");

endmodule

bind voice_bank_two_pole_lowpass vbtpl_checker #(
  .NUM_VOICES (NUM_VOICES)
) u_vbtpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .in_voice  (in_ch.voice),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_voice (out_ch.out_voice),
  .out_level (out_ch.level)
);
